@@ hdl/rtcm3_frame_scanner_defines.svh @@
// ============================================================================
// rtcm3_frame_scanner_defines.svh
// Assertion macros shared by the frame scanner modules.
// ============================================================================
`ifndef RTCM3_FRAME_SCANNER_DEFINES_SVH
`define RTCM3_FRAME_SCANNER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define R3FS_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("frame scanner assertion failed");

// Condition in one cycle implies a condition in the next cycle.
`define R3FS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("frame scanner sequence assertion failed");

`endif

@@ hdl/r3fs_pkg.sv @@
// ============================================================================
// r3fs_pkg
// Types and constants for the RTCM3 frame scanner.
// ============================================================================
`timescale 1ns / 1ps

package r3fs_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [10:0] index_t;
    typedef logic [9:0]  length_t;
    typedef logic [23:0] crc_t;
    typedef logic [15:0] check_t;

    localparam crc_t    CRC_POLY      = 24'h864CFB;   // 0x1864CFB without its top bit
    localparam crc_t    CRC_TOP       = 24'h800000;
    localparam byte_t   RESERVED_MASK = 8'hFC;
    localparam length_t LEN_ZERO      = 10'd0;
    localparam logic [11:0] HEADER_BYTES = 12'd3;

    localparam byte_t   PREAMBLE_RESET = 8'd211;
    localparam length_t MAX_LEN_RESET  = 10'd1023;

    // Configuration register indexes.
    typedef enum logic
    {
        REG_PREAMBLE    = 1'b0,
        REG_MAX_PAYLOAD = 1'b1
    } reg_index_t;

    typedef enum logic [2:0]
    {
        ST_IDLE   = 3'd0,
        ST_BYTE   = 3'd1,
        ST_GOOD   = 3'd2,
        ST_BAD    = 3'd3,
        ST_REJECT = 3'd4
    } status_t;

    typedef enum logic [2:0]
    {
        PH_HUNT    = 3'd0,
        PH_LEN1    = 3'd1,
        PH_LEN2    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CK1     = 3'd4,
        PH_CK2     = 3'd5,
        PH_CK3     = 3'd6
    } phase_t;

    localparam logic CMD_DATA    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed
    {
        status_t status;
        byte_t   byte_out;
        index_t  frame_index;
        length_t payload_length;
    } result_t;

    typedef struct packed
    {
        byte_t   preamble;
        length_t max_payload;
    } cfg_t;

endpackage

@@ hdl/r3fs_in_if.sv @@
// ============================================================================
// r3fs_in_if
// Stream channel carrying one command and byte per beat.
// ============================================================================
`timescale 1ns / 1ps

interface r3fs_in_if;
    import r3fs_pkg::*;

    logic  valid;
    logic  ready;
    logic  cmd;
    byte_t data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

@@ hdl/r3fs_out_if.sv @@
// ============================================================================
// r3fs_out_if
// Result channel: status, byte, frame index and payload length per beat.
// ============================================================================
`timescale 1ns / 1ps

interface r3fs_out_if;
    import r3fs_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    byte_t   byte_out;
    index_t  frame_index;
    length_t payload_length;

    modport source (output valid, output status, output byte_out, output frame_index,
                    output payload_length, input ready);
    modport sink   (input valid, input status, input byte_out, input frame_index,
                    input payload_length, output ready);
endinterface

@@ hdl/r3fs_crc.sv @@
// ============================================================================
// r3fs_crc
// One-byte CRC-24Q update, MSB first, unrolled over the eight bits.
// ============================================================================
`timescale 1ns / 1ps

module r3fs_crc
(
    input  r3fs_pkg::crc_t  crc_in,
    input  r3fs_pkg::byte_t data,
    output r3fs_pkg::crc_t  crc_out
);
    import r3fs_pkg::*;

    always_comb
    begin
        crc_t c;
        c = crc_in ^ {data, 16'h0000};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != '0)
            begin
                c = {c[22:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[22:0], 1'b0};
            end
        end
        crc_out = c;
    end
endmodule

@@ hdl/r3fs_core.sv @@
// ============================================================================
// r3fs_core
// Frame phase tracking, length check and CRC compare for one byte per beat.
// ============================================================================
`timescale 1ns / 1ps
`include "rtcm3_frame_scanner_defines.svh"

module r3fs_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              cmd,
    input  r3fs_pkg::byte_t   data_byte,
    input  r3fs_pkg::cfg_t    cfg,
    output r3fs_pkg::result_t result
);
    import r3fs_pkg::*;

    phase_t  phase_reg,      phase_next;
    index_t  byte_count_reg, byte_count_next;
    length_t length_reg,     length_next;
    crc_t    crc_reg,        crc_next;
    check_t  check_reg,      check_next;

    crc_t    crc_upd;
    length_t full_length;
    logic    payload_last;

    // The accumulator is zero while hunting, so the preamble update uses it too.
    r3fs_crc u_crc
    (
        .crc_in  (crc_reg),
        .data    (data_byte),
        .crc_out (crc_upd)
    );

    assign full_length  = {length_reg[9:8], data_byte};
    assign payload_last = ({1'b0, byte_count_reg} + 12'd1) >= (HEADER_BYTES + {2'b00, length_reg});

    // Next state.
    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        length_next     = length_reg;
        crc_next        = crc_reg;
        check_next      = check_reg;

        if (cmd == CMD_RESTART)
        begin
            phase_next      = PH_HUNT;
            byte_count_next = '0;
            length_next     = '0;
            crc_next        = '0;
            check_next      = '0;
        end
        else
        begin
            case (phase_reg)
                PH_LEN1:
                begin
                    if ((data_byte & RESERVED_MASK) != '0)
                    begin
                        phase_next      = PH_HUNT;
                        byte_count_next = '0;
                        length_next     = '0;
                        crc_next        = '0;
                        check_next      = '0;
                    end
                    else
                    begin
                        phase_next      = PH_LEN2;
                        length_next     = {data_byte[1:0], 8'h00};
                        crc_next        = crc_upd;
                        byte_count_next = byte_count_reg + 11'd1;
                    end
                end
                PH_LEN2:
                begin
                    if (full_length > cfg.max_payload)
                    begin
                        phase_next      = PH_HUNT;
                        byte_count_next = '0;
                        length_next     = '0;
                        crc_next        = '0;
                        check_next      = '0;
                    end
                    else
                    begin
                        phase_next      = (full_length == LEN_ZERO) ? PH_CK1 : PH_PAYLOAD;
                        length_next     = full_length;
                        crc_next        = crc_upd;
                        byte_count_next = byte_count_reg + 11'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    crc_next        = crc_upd;
                    byte_count_next = byte_count_reg + 11'd1;
                    if (payload_last)
                    begin
                        phase_next = PH_CK1;
                    end
                end
                PH_CK1:
                begin
                    check_next      = {8'h00, data_byte};
                    byte_count_next = byte_count_reg + 11'd1;
                    phase_next      = PH_CK2;
                end
                PH_CK2:
                begin
                    check_next      = {check_reg[7:0], data_byte};
                    byte_count_next = byte_count_reg + 11'd1;
                    phase_next      = PH_CK3;
                end
                PH_CK3:
                begin
                    phase_next      = PH_HUNT;
                    byte_count_next = '0;
                    length_next     = '0;
                    crc_next        = '0;
                    check_next      = '0;
                end
                default:
                begin
                    length_next = '0;
                    check_next  = '0;
                    if (data_byte == cfg.preamble)
                    begin
                        phase_next      = PH_LEN1;
                        crc_next        = crc_upd;
                        byte_count_next = 11'd1;
                    end
                    else
                    begin
                        phase_next      = PH_HUNT;
                        crc_next        = '0;
                        byte_count_next = '0;
                    end
                end
            endcase
        end
    end

    // Result for the byte on the input.
    always_comb
    begin
        result.status         = ST_IDLE;
        result.byte_out       = data_byte;
        result.frame_index    = byte_count_reg;
        result.payload_length = length_reg;

        if (cmd == CMD_RESTART)
        begin
            result.byte_out       = '0;
            result.frame_index    = '0;
            result.payload_length = '0;
        end
        else
        begin
            case (phase_reg)
                PH_LEN1:
                begin
                    result.payload_length = '0;
                    result.status = ((data_byte & RESERVED_MASK) != '0) ? ST_REJECT : ST_BYTE;
                end
                PH_LEN2:
                begin
                    result.payload_length = full_length;
                    result.status = (full_length > cfg.max_payload) ? ST_REJECT : ST_BYTE;
                end
                PH_PAYLOAD, PH_CK1, PH_CK2:
                begin
                    result.status = ST_BYTE;
                end
                PH_CK3:
                begin
                    result.status = (crc_reg == {check_reg, data_byte}) ? ST_GOOD : ST_BAD;
                end
                default:
                begin
                    result.frame_index    = '0;
                    result.payload_length = '0;
                    result.status = (data_byte == cfg.preamble) ? ST_BYTE : ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            byte_count_reg <= '0;
            length_reg     <= '0;
            crc_reg        <= '0;
            check_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            length_reg     <= length_next;
            crc_reg        <= crc_next;
            check_reg      <= check_next;
        end
    end

    `R3FS_ASSERT(a_hunt_clean, (phase_reg != PH_HUNT) || (byte_count_reg == '0 && crc_reg == '0))
    `R3FS_ASSERT(a_payload_bound, (phase_reg != PH_PAYLOAD) ||
        (({1'b0, byte_count_reg}) < (HEADER_BYTES + {2'b00, length_reg})))
    `R3FS_ASSERT_NEXT(a_frame_end_rehunt, accept && phase_reg == PH_CK3, phase_reg == PH_HUNT)
    `R3FS_ASSERT_NEXT(a_restart_clears, accept && cmd == CMD_RESTART,
        phase_reg == PH_HUNT && length_reg == '0 && check_reg == '0)
endmodule

@@ hdl/rtcm3_frame_scanner.sv @@
// ============================================================================
// rtcm3_frame_scanner
// RTCM3 frame hunter with CRC-24Q check, one byte per beat.
// ============================================================================
// Bytes enter on the stream channel; cmd high drops any frame in progress and
// restarts the hunt. Every accepted beat gives exactly one beat on the result
// channel: status, the byte, its index within the frame and the payload length.
// The result appears in the cycle after the input beat is taken, from the
// result register. One beat is taken per cycle while the receiver keeps up;
// the unrolled eight-bit CRC-24Q update into the accumulator is combinational.
// Stream ready is high while the result register is empty or is being read,
// so a stalled receiver holds one result and back-pressures the stream.
// The preamble value and the maximum payload length are written through the
// plain write port; doing so only while no beat is pending is left to the user.
// Reset returns the block to hunting, marks the result register empty and
// loads the register defaults (preamble 211, maximum payload 1023).
// ============================================================================
`timescale 1ns / 1ps
`include "rtcm3_frame_scanner_defines.svh"

module rtcm3_frame_scanner
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  r3fs_pkg::reg_index_t   cfg_index,
    input  r3fs_pkg::length_t      cfg_data,
    r3fs_in_if.sink                stream,
    r3fs_out_if.source             result
);
    import r3fs_pkg::*;

    cfg_t    cfg_reg;
    logic    valid_reg;
    result_t result_reg;
    result_t core_result;
    logic    accept;

    assign stream.ready = !valid_reg || result.ready;
    assign accept       = stream.valid && stream.ready;

    r3fs_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (stream.cmd),
        .data_byte (stream.data_byte),
        .cfg       (cfg_reg),
        .result    (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preamble    <= PREAMBLE_RESET;
            cfg_reg.max_payload <= MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PREAMBLE:    cfg_reg.preamble    <= cfg_data[7:0];
                REG_MAX_PAYLOAD: cfg_reg.max_payload <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= core_result;
        end
    end

    assign result.valid          = valid_reg;
    assign result.status         = result_reg.status;
    assign result.byte_out       = result_reg.byte_out;
    assign result.frame_index    = result_reg.frame_index;
    assign result.payload_length = result_reg.payload_length;

    `R3FS_ASSERT_NEXT(a_beat_loads_result, accept, valid_reg)
    `R3FS_ASSERT(a_stall_only_when_full, stream.ready || valid_reg)
    `R3FS_ASSERT_NEXT(a_drain_empties, valid_reg && result.ready && !accept, !valid_reg)
endmodule

@@ tb/rtcm3_frame_scanner_test.sv @@
// ============================================================================
// rtcm3_frame_scanner_test
// Self-checking testbench for the RTCM3 frame scanner.
// ============================================================================
// A short table of directed beats covers hunting, restarts, reserved length
// bits, the largest and the zero payload length, rejected lengths and good
// and bad checksums. Random frames follow under several register settings.
// Result beats are checked against table rows or a cycle-free scanner model.
// The sender works in bursts and the receiver stalls in patterns. At times
// the receiver holds off for a long stretch.
// ============================================================================
`timescale 1ns / 1ps

module rtcm3_frame_scanner_test;
    import r3fs_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam result_t NO_RESULT = '0;

    typedef enum logic [1:0]
    {
        ROW_BEAT,
        ROW_CRC,
        ROW_CFG
    } row_kind_t;

    typedef struct
    {
        row_kind_t  kind;
        logic       cmd;
        byte_t      data;
        reg_index_t sel;
        length_t    value;
        bit         typed;
        result_t    want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    reg_index_t cfg_index;
    length_t cfg_data;

    r3fs_in_if  stream_ch ();
    r3fs_out_if result_ch ();

    rtcm3_frame_scanner uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stream    (stream_ch),
        .result    (result_ch)
    );

    always #CLK_HALF clk = ~clk;

    // Scanner model state and register copy.
    cfg_t    model_cfg;
    phase_t  scan_phase;
    index_t  scan_count;
    length_t scan_len;
    crc_t    scan_crc;
    check_t  scan_check;

    result_t scan_results_due [$];
    plan_row_t plan [$];

    int failures = 0;
    int beats_sent = 0;
    int results_checked = 0;
    int crc_good_seen = 0;
    int crc_bad_seen = 0;
    int rejects_seen = 0;
    int burst_left = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int pattern_left = 0;
    int stall_mode = 0;
    int cycle_count = 0;

    function automatic crc_t crc24q_byte(crc_t c, byte_t b);
        crc_t acc;
        int k;
        acc = c ^ {b, 16'h0000};
        for (k = 0; k < 8; k++)
        begin
            if ((acc & CRC_TOP) != 0)
                acc = {acc[22:0], 1'b0} ^ CRC_POLY;
            else
                acc = {acc[22:0], 1'b0};
        end
        return acc;
    endfunction

    function automatic void clear_scan();
        scan_phase = PH_HUNT;
        scan_count = '0;
        scan_len   = '0;
        scan_crc   = '0;
        scan_check = '0;
    endfunction

    function automatic result_t predict_scan(logic cmd, byte_t b);
        result_t r;
        r.status         = ST_IDLE;
        r.byte_out       = b;
        r.frame_index    = '0;
        r.payload_length = '0;
        if (cmd == CMD_RESTART)
        begin
            clear_scan();
            r.byte_out = '0;
        end
        else
        begin
            r.frame_index = scan_count;
            case (scan_phase)
                PH_LEN1:
                begin
                    if ((b & RESERVED_MASK) != 0)
                    begin
                        r.status = ST_REJECT;
                        clear_scan();
                    end
                    else
                    begin
                        r.status = ST_BYTE;
                        scan_len = {b[1:0], 8'h00};
                        scan_crc = crc24q_byte(scan_crc, b);
                        scan_count++;
                        scan_phase = PH_LEN2;
                    end
                end
                PH_LEN2:
                begin
                    scan_len = scan_len | length_t'(b);
                    r.payload_length = scan_len;
                    if (scan_len > model_cfg.max_payload)
                    begin
                        r.status = ST_REJECT;
                        clear_scan();
                    end
                    else
                    begin
                        r.status = ST_BYTE;
                        scan_crc = crc24q_byte(scan_crc, b);
                        scan_count++;
                        scan_phase = (scan_len == LEN_ZERO) ? PH_CK1 : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    r.status = ST_BYTE;
                    r.payload_length = scan_len;
                    scan_crc = crc24q_byte(scan_crc, b);
                    if (int'(scan_count) + 1 >= int'(HEADER_BYTES) + int'(scan_len))
                        scan_phase = PH_CK1;
                    scan_count++;
                end
                PH_CK1:
                begin
                    r.status = ST_BYTE;
                    r.payload_length = scan_len;
                    scan_check = {8'h00, b};
                    scan_count++;
                    scan_phase = PH_CK2;
                end
                PH_CK2:
                begin
                    r.status = ST_BYTE;
                    r.payload_length = scan_len;
                    scan_check = {scan_check[7:0], b};
                    scan_count++;
                    scan_phase = PH_CK3;
                end
                PH_CK3:
                begin
                    r.payload_length = scan_len;
                    r.status = (scan_crc == {scan_check, b}) ? ST_GOOD : ST_BAD;
                    clear_scan();
                end
                default:
                begin
                    clear_scan();
                    r.frame_index = '0;
                    if (b == model_cfg.preamble)
                    begin
                        r.status   = ST_BYTE;
                        scan_crc   = crc24q_byte('0, b);
                        scan_count = 11'd1;
                        scan_phase = PH_LEN1;
                    end
                end
            endcase
        end
        return r;
    endfunction

    function automatic plan_row_t blank_row(row_kind_t k);
        plan_row_t p;
        p.kind  = k;
        p.cmd   = CMD_DATA;
        p.data  = '0;
        p.sel   = REG_PREAMBLE;
        p.value = '0;
        p.typed = 1'b0;
        p.want  = NO_RESULT;
        return p;
    endfunction

    function automatic plan_row_t open_row(logic c, byte_t d);
        plan_row_t p;
        p      = blank_row(ROW_BEAT);
        p.cmd  = c;
        p.data = d;
        return p;
    endfunction

    function automatic plan_row_t typed_row(logic c, byte_t d, status_t st, byte_t bo,
                                            index_t idx, length_t pl);
        plan_row_t p;
        p = open_row(c, d);
        p.typed = 1'b1;
        p.want.status         = st;
        p.want.byte_out       = bo;
        p.want.frame_index    = idx;
        p.want.payload_length = pl;
        return p;
    endfunction

    function automatic plan_row_t crc_row(byte_t flip);
        plan_row_t p;
        p      = blank_row(ROW_CRC);
        p.data = flip;
        return p;
    endfunction

    function automatic plan_row_t cfg_row(reg_index_t sel, length_t value);
        plan_row_t p;
        p       = blank_row(ROW_CFG);
        p.sel   = sel;
        p.value = value;
        return p;
    endfunction

    // Offers one beat and waits for it to be taken. With crc_fill set, the byte
    // is the model's running checksum byte for this position, xored with data.
    task automatic send_beat(logic cmd, byte_t data, bit crc_fill, bit typed, result_t want);
        int gap;
        byte_t d;
        result_t predicted;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                stream_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        @(negedge clk);
        d = data;
        if (crc_fill)
        begin
            case (scan_phase)
                PH_CK1:  d = scan_crc[23:16] ^ data;
                PH_CK2:  d = scan_crc[15:8] ^ data;
                default: d = scan_crc[7:0] ^ data;
            endcase
        end
        stream_ch.valid     <= 1'b1;
        stream_ch.cmd       <= cmd;
        stream_ch.data_byte <= d;
        do
            @(posedge clk);
        while (stream_ch.ready !== 1'b1);
        predicted = predict_scan(cmd, d);
        scan_results_due.push_back(typed ? want : predicted);
        beats_sent++;
        burst_left--;
    endtask

    task automatic drain_results();
        @(negedge clk);
        stream_ch.valid <= 1'b0;
        while (scan_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(reg_index_t sel, length_t value);
        drain_results();
        repeat (2) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (sel == REG_PREAMBLE)
            model_cfg.preamble = value[7:0];
        else
            model_cfg.max_payload = value;
    endtask

    // One random frame, or a short run of noise. A forced length gives a
    // well-formed frame of exactly that payload length.
    task automatic send_frame(int forced_len);
        int roll;
        int len;
        int len_cap;
        int cut;
        int bad_pos;
        int pos;
        byte_t flip;
        roll = (forced_len >= 0) ? 99 : $urandom_range(0, 99);
        len_cap = (model_cfg.max_payload < 12) ? int'(model_cfg.max_payload) : 12;
        if ($urandom_range(0, 9) == 0)
            len_cap = (model_cfg.max_payload < 40) ? int'(model_cfg.max_payload) : 40;
        len = (forced_len >= 0) ? forced_len : $urandom_range(0, len_cap);
        cut = -1;
        bad_pos = -1;
        flip = 8'h00;
        if (roll < 8)
        begin
            repeat ($urandom_range(1, 6))
                send_beat(CMD_DATA, byte_t'($urandom), 1'b0, 1'b0, NO_RESULT);
            if ($urandom_range(0, 2) == 0)
                send_beat(CMD_RESTART, byte_t'($urandom), 1'b0, 1'b0, NO_RESULT);
        end
        else
        begin
            send_beat(CMD_DATA, model_cfg.preamble, 1'b0, 1'b0, NO_RESULT);
            if (roll < 14)
                send_beat(CMD_DATA, byte_t'($urandom_range(4, 255)), 1'b0, 1'b0, NO_RESULT);
            else
            begin
                if (roll < 22 && model_cfg.max_payload != MAX_LEN_RESET)
                    len = $urandom_range(int'(model_cfg.max_payload) + 1, 1023);
                send_beat(CMD_DATA, byte_t'(len >> 8), 1'b0, 1'b0, NO_RESULT);
                send_beat(CMD_DATA, byte_t'(len), 1'b0, 1'b0, NO_RESULT);
                if (len <= int'(model_cfg.max_payload))
                begin
                    if (roll >= 22 && roll < 30)
                        cut = $urandom_range(0, len + 2);
                    if (roll >= 30 && roll < 40)
                    begin
                        bad_pos = len + $urandom_range(0, 2);
                        flip = byte_t'($urandom_range(1, 255));
                    end
                    for (pos = 0; pos < len + 3; pos++)
                    begin
                        if (pos == cut)
                        begin
                            send_beat(CMD_RESTART, byte_t'($urandom), 1'b0, 1'b0, NO_RESULT);
                            break;
                        end
                        if (pos < len)
                            send_beat(CMD_DATA, byte_t'($urandom), 1'b0, 1'b0, NO_RESULT);
                        else
                            send_beat(CMD_DATA, (pos == bad_pos) ? flip : 8'h00, 1'b1, 1'b0,
                                      NO_RESULT);
                    end
                end
            end
        end
    endtask

    task automatic check_field(string name, logic [10:0] want, logic [10:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (scan_results_due.size() == 0)
            begin
                $error("result beat arrived with no result expected");
                failures++;
            end
            else
            begin
                want = scan_results_due.pop_front();
                check_field("status", 11'(want.status), 11'(result_ch.status));
                check_field("byte_out", 11'(want.byte_out), 11'(result_ch.byte_out));
                check_field("frame_index", want.frame_index, result_ch.frame_index);
                check_field("payload_length", 11'(want.payload_length),
                            11'(result_ch.payload_length));
                results_checked++;
                if (result_ch.status == ST_GOOD)
                    crc_good_seen++;
                else if (result_ch.status == ST_BAD)
                    crc_bad_seen++;
                else if (result_ch.status == ST_REJECT)
                    rejects_seen++;
            end
        end
    end

    // Receiver: a random choice of stall patterns, and on request a long hold-off
    // during which the stream side must back up.
    always @(negedge clk)
    begin
        if (holds_served < hold_requests)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (pattern_left <= 0)
            begin
                stall_mode = $urandom_range(0, 3);
                pattern_left = $urandom_range(20, 80);
            end
            pattern_left--;
            case (stall_mode)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       result_ch.ready <= 1'($urandom_range(0, 1));
                default: result_ch.ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int ph;
        int target;
        bit paused;
        byte_t pre;
        length_t maxp;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_PREAMBLE;
        cfg_data = '0;
        stream_ch.valid = 1'b0;
        stream_ch.cmd = CMD_DATA;
        stream_ch.data_byte = '0;
        result_ch.ready = 1'b0;
        model_cfg.preamble = PREAMBLE_RESET;
        model_cfg.max_payload = MAX_LEN_RESET;
        clear_scan();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Hunting, restart, reserved bits on a second preamble, zero length.
        plan.push_back(typed_row(CMD_DATA, 8'h00, ST_IDLE, 8'h00, 11'd0, 10'd0));
        plan.push_back(typed_row(CMD_RESTART, 8'hAB, ST_IDLE, 8'h00, 11'd0, 10'd0));
        plan.push_back(typed_row(CMD_DATA, PREAMBLE_RESET, ST_BYTE, PREAMBLE_RESET,
                                 11'd0, 10'd0));
        plan.push_back(typed_row(CMD_DATA, PREAMBLE_RESET, ST_REJECT, PREAMBLE_RESET,
                                 11'd1, 10'd0));
        plan.push_back(typed_row(CMD_DATA, PREAMBLE_RESET, ST_BYTE, PREAMBLE_RESET,
                                 11'd0, 10'd0));
        plan.push_back(typed_row(CMD_DATA, 8'h00, ST_BYTE, 8'h00, 11'd1, 10'd0));
        plan.push_back(typed_row(CMD_DATA, 8'h00, ST_BYTE, 8'h00, 11'd2, 10'd0));
        plan.push_back(crc_row(8'h00));
        plan.push_back(crc_row(8'h00));
        plan.push_back(crc_row(8'h00));
        // Largest length is accepted, then the frame is dropped by a restart.
        plan.push_back(open_row(CMD_DATA, PREAMBLE_RESET));
        plan.push_back(open_row(CMD_DATA, 8'h03));
        plan.push_back(typed_row(CMD_DATA, 8'hFF, ST_BYTE, 8'hFF, 11'd2, MAX_LEN_RESET));
        plan.push_back(typed_row(CMD_RESTART, 8'h5A, ST_IDLE, 8'h00, 11'd0, 10'd0));
        // Two-byte payload with a corrupted last checksum byte.
        plan.push_back(open_row(CMD_DATA, PREAMBLE_RESET));
        plan.push_back(open_row(CMD_DATA, 8'h00));
        plan.push_back(typed_row(CMD_DATA, 8'h02, ST_BYTE, 8'h02, 11'd2, 10'd2));
        plan.push_back(open_row(CMD_DATA, 8'h55));
        plan.push_back(open_row(CMD_DATA, 8'hAA));
        plan.push_back(crc_row(8'h00));
        plan.push_back(crc_row(8'h00));
        plan.push_back(crc_row(8'h01));
        // Zero preamble and zero length limit: any nonzero payload length is rejected.
        plan.push_back(cfg_row(REG_PREAMBLE, 10'h300));
        plan.push_back(cfg_row(REG_MAX_PAYLOAD, 10'd0));
        plan.push_back(typed_row(CMD_DATA, 8'h00, ST_BYTE, 8'h00, 11'd0, 10'd0));
        plan.push_back(typed_row(CMD_DATA, 8'h00, ST_BYTE, 8'h00, 11'd1, 10'd0));
        plan.push_back(typed_row(CMD_DATA, 8'h01, ST_REJECT, 8'h01, 11'd2, 10'd1));

        foreach (plan[i])
        begin
            case (plan[i].kind)
                ROW_CFG: write_register(plan[i].sel, plan[i].value);
                ROW_CRC: send_beat(CMD_DATA, plan[i].data, 1'b1, 1'b0, NO_RESULT);
                default: send_beat(plan[i].cmd, plan[i].data, 1'b0, plan[i].typed,
                                   plan[i].want);
            endcase
        end

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    pre = PREAMBLE_RESET;
                    maxp = MAX_LEN_RESET;
                end
                1:
                begin
                    pre = 8'h00;
                    maxp = 10'd0;
                end
                2:
                begin
                    pre = 8'hFF;
                    maxp = MAX_LEN_RESET;
                end
                3:
                begin
                    pre = byte_t'($urandom);
                    maxp = length_t'($urandom_range(1, 30));
                end
                4:
                begin
                    pre = byte_t'($urandom);
                    maxp = length_t'($urandom);
                end
                default:
                begin
                    pre = PREAMBLE_RESET;
                    maxp = MAX_LEN_RESET;
                end
            endcase
            write_register(REG_PREAMBLE, length_t'({2'($urandom_range(0, 3)), pre}));
            write_register(REG_MAX_PAYLOAD, maxp);
            if (ph == 2 || ph == 4)
                hold_requests++;
            target = beats_sent + 165;
            paused = 1'b0;
            while (beats_sent < target)
            begin
                send_frame(-1);
                // Let the result side empty completely once, mid-phase.
                if (ph == 3 && !paused && beats_sent > target - 80)
                begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (scan_results_due.size() != 0)
        begin
            $error("%0d expected result beats never arrived", scan_results_due.size());
            failures++;
        end

        $display("Sent %0d stream beats and checked %0d result beats: %0d good CRC,",
                 beats_sent, results_checked, crc_good_seen);
        $display("%0d bad CRC and %0d rejected frames, over six register settings.",
                 crc_bad_seen, rejects_seen);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
